// ----- rtl/core/mi3_pkg.sv -----
// mi3_pkg: shared constants for the 3x3 matrix inverse
// default element format used by the interfaces and the top level
`timescale 1ns / 1ps

package mi3_pkg;

    // element width and fraction bits, Q16.16 by default
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

// ----- rtl/core/mi3_if.sv -----
// mi3_in_if / mi3_out_if: valid-ready channels for matrix and inverse items
// depends on mi3_pkg for the default element width
`timescale 1ns / 1ps

interface mi3_in_if #(
    parameter int ElemWidth = mi3_pkg::ELEM_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [ElemWidth-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

    modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    input ready);
    modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    output ready);
endinterface

interface mi3_out_if #(
    parameter int ElemWidth = mi3_pkg::ELEM_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [ElemWidth-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic                        singular;
    logic                        clamped;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, clamped, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, clamped, output ready);
endinterface

// ----- rtl/core/mi3_div_lane.sv -----
// mi3_div_lane: pipelined restoring divider for one inverse element
// one overflow check stage, then one quotient bit per stage, then saturation
`timescale 1ns / 1ps

module mi3_div_lane #(
    parameter int ElemWidth = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int NumWidth  = 4 * mi3_pkg::ELEM_WIDTH_DEF + 1,
    parameter int DenWidth  = 3 * mi3_pkg::ELEM_WIDTH_DEF + 3
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [NumWidth-1:0]         num,
    input  logic [DenWidth-1:0]         den,
    input  logic                        neg,
    output logic signed [ElemWidth-1:0] result,
    output logic                        clamp
);
    import mi3_pkg::*;

    localparam int DSW = DenWidth + ElemWidth;
    localparam int CW  = ((NumWidth > DSW) ? NumWidth : DSW) + 1;
    localparam logic [ElemWidth-1:0] HALF = {1'b1, {(ElemWidth-1){1'b0}}};

    logic [CW-1:0]        rem_reg [0:ElemWidth];
    logic [DenWidth-1:0]  den_reg [0:ElemWidth];
    logic [ElemWidth-1:0] q_reg   [0:ElemWidth];
    logic                 ovf_reg [0:ElemWidth];
    logic                 neg_reg [0:ElemWidth];

    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_top;

    assign num_ext = {{(CW-NumWidth){1'b0}}, num};
    assign den_top = {{(CW-DenWidth){1'b0}}, den} << ElemWidth;

    // overflow check: quotient at or above 2^ElemWidth saturates anyway
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num_ext >= den_top);
            neg_reg[0] <= neg;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= ElemWidth; k++)
    begin : g_bit
        logic [CW-1:0] dsh;
        logic          take;

        assign dsh  = {{(CW-DenWidth){1'b0}}, den_reg[k-1]} << (ElemWidth - k);
        assign take = (rem_reg[k-1] >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][ElemWidth-2:0], take};
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // sign and saturation
    always_comb
    begin
        logic [ElemWidth-1:0] q;
        q = q_reg[ElemWidth];
        if (neg_reg[ElemWidth])
        begin
            clamp  = ovf_reg[ElemWidth] || (q > HALF);
            result = clamp ? $signed(HALF) : $signed(-q);
        end
        else
        begin
            clamp  = ovf_reg[ElemWidth] || q[ElemWidth-1];
            result = clamp ? $signed(HALF - 1'b1) : $signed(q);
        end
    end

endmodule

// ----- rtl/core/matrix3x3_inverse.sv -----
// matrix3x3_inverse: exact 3x3 fixed-point inverse by adjugate and determinant
// depends on mi3_pkg, mi3_in_if, mi3_out_if and mi3_div_lane
`timescale 1ns / 1ps

// Usage
// in_ch carries one matrix per item (e00..e22, signed fixed point, row major);
// out_ch carries its inverse (r00..r22), singular and clamped.
// Pipeline: six arithmetic stages (cofactor products, cofactors, split
// determinant products, their recombination, determinant, magnitudes), then
// ElemWidth+1 divider stages (one overflow check, one quotient bit each),
// then the output register.
// Throughput is one item per clock while out_ch is not stalled; all nine
// elements divide in parallel lanes.
// The whole pipeline advances together: while out_ch holds a result that
// is not taken, in_ch.ready is low and every stage keeps its contents, so
// nothing is lost or repeated. in_ch.ready is high whenever the output
// register is empty or being taken.
// Reset clears all valid bits; no payload is reset and no warm-up is needed.
// A zero determinant gives all-zero elements with singular set.

module matrix3x3_inverse #(
    parameter int ElemWidth = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FracBits  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mi3_in_if.sink    in_ch,
    mi3_out_if.source out_ch
);
    import mi3_pkg::*;

    localparam int W   = ElemWidth;
    localparam int PW  = 2 * W;
    localparam int AW  = 2 * W + 1;
    localparam int LW  = W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NMW = AW + 2 * FracBits;
    localparam int DL  = W + 1;

    logic en;
    logic signed [W-1:0] e_in [0:8];

    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    assign e_in[0] = in_ch.e00;
    assign e_in[1] = in_ch.e01;
    assign e_in[2] = in_ch.e02;
    assign e_in[3] = in_ch.e10;
    assign e_in[4] = in_ch.e11;
    assign e_in[5] = in_ch.e12;
    assign e_in[6] = in_ch.e20;
    assign e_in[7] = in_ch.e21;
    assign e_in[8] = in_ch.e22;

    // valid bits of the arithmetic and divider stages, singular flags of the divider stages
    logic [5:0]    vld_reg;
    logic [DL-1:0] vdiv_reg;
    logic [DL-1:0] sdiv_reg;

    // stage 1: cofactor products
    logic signed [PW-1:0] p_reg [0:17];
    logic signed [W-1:0]  r0_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]  <= e_in[4] * e_in[8];
            p_reg[1]  <= e_in[5] * e_in[7];
            p_reg[2]  <= e_in[2] * e_in[7];
            p_reg[3]  <= e_in[1] * e_in[8];
            p_reg[4]  <= e_in[1] * e_in[5];
            p_reg[5]  <= e_in[2] * e_in[4];
            p_reg[6]  <= e_in[5] * e_in[6];
            p_reg[7]  <= e_in[3] * e_in[8];
            p_reg[8]  <= e_in[0] * e_in[8];
            p_reg[9]  <= e_in[2] * e_in[6];
            p_reg[10] <= e_in[2] * e_in[3];
            p_reg[11] <= e_in[0] * e_in[5];
            p_reg[12] <= e_in[3] * e_in[7];
            p_reg[13] <= e_in[4] * e_in[6];
            p_reg[14] <= e_in[1] * e_in[6];
            p_reg[15] <= e_in[0] * e_in[7];
            p_reg[16] <= e_in[0] * e_in[4];
            p_reg[17] <= e_in[1] * e_in[3];
            r0_reg[0] <= e_in[0];
            r0_reg[1] <= e_in[1];
            r0_reg[2] <= e_in[2];
        end
    end

    // stage 2: adjugate entries
    logic signed [AW-1:0] adj2_reg [0:8];
    logic signed [W-1:0]  r2_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                adj2_reg[i] <= $signed({p_reg[2*i][PW-1], p_reg[2*i]})
                             - $signed({p_reg[2*i+1][PW-1], p_reg[2*i+1]});
            end
            for (int i = 0; i < 3; i++)
            begin
                r2_reg[i] <= r0_reg[i];
            end
        end
    end

    // stage 3: first-row times cofactor, split into low and high halves
    logic signed [PW+1:0] pl_reg [0:2];
    logic signed [PW-1:0] ph_reg [0:2];
    logic signed [AW-1:0] adj3_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[k] <= r2_reg[k] * $signed({1'b0, adj2_reg[3*k][LW-1:0]});
                ph_reg[k] <= r2_reg[k] * $signed(adj2_reg[3*k][AW-1:LW]);
            end
            adj3_reg <= adj2_reg;
        end
    end

    // stage 4: recombine the halves
    logic signed [DW-1:0] t_reg [0:2];
    logic signed [AW-1:0] adj4_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k] <= ($signed({{(DW-PW){ph_reg[k][PW-1]}}, ph_reg[k]}) <<< LW)
                          + $signed({{(DW-PW-2){pl_reg[k][PW+1]}}, pl_reg[k]});
            end
            adj4_reg <= adj3_reg;
        end
    end

    // stage 5: determinant
    logic signed [DW-1:0] det_reg;
    logic signed [AW-1:0] adj5_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg  <= t_reg[0] + t_reg[1] + t_reg[2];
            adj5_reg <= adj4_reg;
        end
    end

    // stage 6: magnitudes and signs for the dividers
    logic [DW-1:0]  dmag_reg;
    logic           dzero_reg;
    logic [NMW-1:0] nmag_reg [0:8];
    logic [8:0]     qneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg  <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            dzero_reg <= (det_reg == '0);
            for (int i = 0; i < 9; i++)
            begin
                nmag_reg[i] <= {(adj5_reg[i][AW-1] ? AW'(-adj5_reg[i])
                                                   : AW'(adj5_reg[i])),
                                {(2*FracBits){1'b0}}};
                qneg_reg[i] <= adj5_reg[i][AW-1] ^ det_reg[DW-1];
            end
        end
    end

    // valid and singular travel beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vdiv_reg <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[4:0], in_ch.valid};
            vdiv_reg <= {vdiv_reg[DL-2:0], vld_reg[5]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sdiv_reg <= {sdiv_reg[DL-2:0], dzero_reg};
        end
    end

    // nine divider lanes
    logic signed [W-1:0] q_res [0:8];
    logic [8:0]          q_clamp;

    for (genvar i = 0; i < 9; i++)
    begin : g_lane
        mi3_div_lane #(
            .ElemWidth (W),
            .NumWidth  (NMW),
            .DenWidth  (DW)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .num    (nmag_reg[i]),
            .den    (dmag_reg),
            .neg    (qneg_reg[i]),
            .result (q_res[i]),
            .clamp  (q_clamp[i])
        );
    end

    // output register
    logic                out_vld_reg;
    logic signed [W-1:0] r_reg [0:8];
    logic                sing_reg;
    logic                clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vdiv_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                r_reg[i] <= sdiv_reg[DL-1] ? '0 : q_res[i];
            end
            sing_reg  <= sdiv_reg[DL-1];
            clamp_reg <= !sdiv_reg[DL-1] && (|q_clamp);
        end
    end

    assign out_ch.valid    = out_vld_reg;
    assign out_ch.r00      = r_reg[0];
    assign out_ch.r01      = r_reg[1];
    assign out_ch.r02      = r_reg[2];
    assign out_ch.r10      = r_reg[3];
    assign out_ch.r11      = r_reg[4];
    assign out_ch.r12      = r_reg[5];
    assign out_ch.r20      = r_reg[6];
    assign out_ch.r21      = r_reg[7];
    assign out_ch.r22      = r_reg[8];
    assign out_ch.singular = sing_reg;
    assign out_ch.clamped  = clamp_reg;

    // a singular result is all zero and never clamped
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.singular |->
            !out_ch.clamped && out_ch.r00 == '0 && out_ch.r22 == '0)
        else $error("singular result not cleared");

    // a stalled pipeline keeps its valid bits
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg) && $stable(vdiv_reg))
        else $error("pipeline moved during stall");

    // an accepted item enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg[0])
        else $error("accepted item lost");

endmodule

// ----- tb/mi3_inverse_checker.sv -----
// mi3_inverse_checker: predicts each matrix inverse and compares it with out_ch
// depends on mi3_pkg and the mi3_in_if / mi3_out_if channels
`timescale 1ns / 1ps

module mi3_inverse_checker (
    input  logic     clk,
    input  logic     rst_n,
    mi3_in_if        in_ch,
    mi3_out_if       out_ch,
    output int       errors,
    output int       pending,
    output int       results_seen,
    output int       singular_seen,
    output int       clamped_seen
);
    import mi3_pkg::*;

    localparam int W = ELEM_WIDTH_DEF;
    localparam int F = FRAC_BITS_DEF;

    typedef struct packed {
        logic signed [W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic                singular;
        logic                clamped;
    } inverse_t;

    inverse_t inverse_q[$];

    // exact adjugate inverse with saturation
    function automatic inverse_t invert_matrix(input logic signed [W-1:0] m [9]);
        logic signed [255:0] e [9];
        logic signed [255:0] adj [9];
        logic signed [255:0] det, num, q, dmag, nmag;
        logic signed [255:0] maxpos, minneg;
        logic signed [W-1:0] res [9];
        inverse_t r;
        logic clamp;
        clamp  = 1'b0;
        maxpos = (256'sd1 <<< (W - 1)) - 1;
        minneg = -(256'sd1 <<< (W - 1));
        for (int i = 0; i < 9; i++)
            e[i] = m[i];
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        dmag = (det < 0) ? -det : det;
        for (int i = 0; i < 9; i++)
        begin
            num  = adj[i] <<< (2 * F);
            nmag = (num < 0) ? -num : num;
            q = (det == 0) ? 256'sd0 : nmag / dmag;
            if ((num < 0) != (det < 0))
                q = -q;
            if (det == 0)
                res[i] = '0;
            else if (q > maxpos)
            begin
                res[i] = maxpos[W-1:0];
                clamp  = 1'b1;
            end
            else if (q < minneg)
            begin
                res[i] = minneg[W-1:0];
                clamp  = 1'b1;
            end
            else
                res[i] = q[W-1:0];
        end
        r.r00 = res[0]; r.r01 = res[1]; r.r02 = res[2];
        r.r10 = res[3]; r.r11 = res[4]; r.r12 = res[5];
        r.r20 = res[6]; r.r21 = res[7]; r.r22 = res[8];
        r.singular = (det == 0);
        r.clamped  = clamp;
        return r;
    endfunction

    // record expectations on input acceptance, compare on output acceptance
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [W-1:0] m [9];
        inverse_t got, want;
        if (!rst_n)
        begin
            errors        <= 0;
            results_seen  <= 0;
            singular_seen <= 0;
            clamped_seen  <= 0;
            inverse_q.delete();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10, out_ch.r11,
                        out_ch.r12, out_ch.r20, out_ch.r21, out_ch.r22,
                        out_ch.singular, out_ch.clamped};
                results_seen <= results_seen + 1;
                if (inverse_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result item: %p", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (want.singular) singular_seen <= singular_seen + 1;
                    if (want.clamped)  clamped_seen  <= clamped_seen + 1;
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("mismatch at %0t\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                m = '{in_ch.e00, in_ch.e01, in_ch.e02, in_ch.e10, in_ch.e11,
                      in_ch.e12, in_ch.e20, in_ch.e21, in_ch.e22};
                inverse_q.push_back(invert_matrix(m));
            end
        end
    end

    assign pending = inverse_q.size();

endmodule

// ----- tb/tb_matrix3x3_inverse.sv -----
// tb_matrix3x3_inverse: stimulus and verdict for the 3x3 matrix inverse
// depends on mi3_pkg, the channel interfaces, the block and mi3_inverse_checker
`timescale 1ns / 1ps

module tb_matrix3x3_inverse;
    import mi3_pkg::*;

    localparam int W         = ELEM_WIDTH_DEF;
    localparam int LATENCY   = W + 8;
    localparam int NUM_RAND  = 330;
    localparam int IDLE_MAX  = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors, pending, results_seen, singular_seen, clamped_seen;
    int   idle_cycles = 0;
    bit   sender_calm = 1'b0;
    bit   receiver_calm = 1'b0;
    bit   hold_off = 1'b0;

    typedef logic signed [W-1:0] elem_t;

    always #4 clk = ~clk;

    mi3_in_if  in_ch ();
    mi3_out_if out_ch ();

    matrix3x3_inverse dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mi3_inverse_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .singular_seen (singular_seen),
        .clamped_seen  (clamped_seen)
    );

    // receiver: random stalls, a calm stretch, and a long hold-off
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= receiver_calm || ($urandom_range(99) >= 33);
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("tb_matrix3x3_inverse: errors");
            $finish;
        end
    end

    function automatic elem_t rand_elem(input int mode);
        case (mode)
            0: rand_elem = elem_t'($urandom);
            1: rand_elem = elem_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: rand_elem = elem_t'($signed($urandom_range(0, 1024)) - 512);
            default: rand_elem = ($urandom_range(1)) ? elem_t'(32'h7fffffff)
                                                     : elem_t'(32'h80000000);
        endcase
    endfunction

    // offer one matrix, with random gaps, until it is accepted
    task automatic send_matrix(input elem_t m [9]);
        while (!sender_calm && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.e00, in_ch.e01, in_ch.e02, in_ch.e10, in_ch.e11,
         in_ch.e12, in_ch.e20, in_ch.e21, in_ch.e22} <=
            {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_diag(input elem_t a, input elem_t b, input elem_t c);
        elem_t m [9];
        m = '{a, 0, 0, 0, b, 0, 0, 0, c};
        send_matrix(m);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        elem_t m [9];
        int mode;
        in_ch.valid <= 1'b0;
        {in_ch.e00, in_ch.e01, in_ch.e02, in_ch.e10, in_ch.e11,
         in_ch.e12, in_ch.e20, in_ch.e21, in_ch.e22} <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, scaling, singular, clamping, extremes
        send_diag(32'sh10000, 32'sh10000, 32'sh10000);
        send_diag(32'sh20000, -32'sh8000, 32'sh30000);
        send_diag(1, 1, 1);
        send_diag(-1, 1, 32'sh10000);
        send_diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_diag(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_diag(32'sh80000000, 32'sh7fffffff, -1);
        m = '{default: 0};
        send_matrix(m);
        m = '{default: 32'shffffffff};
        send_matrix(m);
        m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
              32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000};
        send_matrix(m);
        m = '{0, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
        send_matrix(m);
        m = '{32'sh20000, -32'sh10000, 0, -32'sh10000, 32'sh20000, -32'sh10000,
              0, -32'sh10000, 32'sh20000};
        send_matrix(m);
        m = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh12345678, 32'sh80000000, 32'sh7fffffff};
        send_matrix(m);
        m = '{32'sh55555555, 32'shaaaaaaaa, 3, 32'shaaaaaaaa, 32'sh55555555,
              7, 5, 9, 32'sh55555555};
        send_matrix(m);

        // pause until every result is back
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        fork
        begin
            hold_off = 1'b1;
            repeat (LATENCY * 3) @(posedge clk);
            hold_off = 1'b0;
        end
        begin
            sender_calm = 1'b1;
            for (int k = 0; k < 60; k++)
            begin
                foreach (m[j]) m[j] = rand_elem(1);
                send_matrix(m);
            end
            sender_calm = 1'b0;
        end
        join

        // random matrices, with a calm stretch in the middle
        for (int n = 0; n < NUM_RAND; n++)
        begin
            sender_calm   = (n >= 150 && n < 230);
            receiver_calm = sender_calm;
            mode = $urandom_range(9);
            mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
            foreach (m[j]) m[j] = rand_elem(($urandom_range(9) == 0) ? 3 : mode);
            // make some rows dependent so singular results occur
            if ($urandom_range(9) == 0)
            begin
                m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
            end
            send_matrix(m);
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;

        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);

        $display("%0d inverses checked, %0d singular and %0d saturated among them",
                 results_seen, singular_seen, clamped_seen);
        if (errors == 0 && pending == 0)
            $display("tb_matrix3x3_inverse: clean");
        else
            $display("tb_matrix3x3_inverse: errors");
        $finish;
    end

endmodule
